/* hdl/tile_ram_first_fit_allocator_core_macros.svh */
// Assertion macros for the tile RAM first-fit allocator.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef TILE_RAM_FIRST_FIT_ALLOCATOR_CORE_MACROS_SVH
`define TILE_RAM_FIRST_FIT_ALLOCATOR_CORE_MACROS_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define TRFA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Checks that an antecedent implies a consequent in the next cycle.
`define TRFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/trfa_pkg.sv */
// Package for the tile RAM first-fit allocator: payload types, codes and sizes.
// No dependencies.
package trfa_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int ADDR_W = $clog2(MAX_SEGMENTS);
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int TILE_SPACE = 2048;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_UNLOAD_INDEX = 2'd1;
  localparam logic [1:0] OP_UNLOAD_TAG = 2'd2;
  localparam logic [1:0] OP_FIND_TAG = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_NO_SPACE = 2'd3;

  localparam logic [15:0] INDEX_NONE = 16'hFFFF;

  localparam logic CFG_BASE_TILE = 1'b0;
  localparam logic CFG_TILE_LIMIT = 1'b1;

  typedef struct packed {
    logic [1:0] operation;
    logic [11:0] tile_count;
    logic [10:0] tile_start;
    logic [15:0] tag;
  } in_item_t;

  typedef struct packed {
    logic [15:0] result_index;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [10:0] start;
    logic [11:0] length;
    logic [15:0] tag;
  } segment_t;

endpackage

/* hdl/tile_ram_first_fit_allocator_core.sv */
// Top level of the tile RAM first-fit allocator: command sequencer and table RAM.
// Depends on trfa_pkg, trfa_ram and the assertion macro header.
//
// Usage: drive cmd with start high while busy is low; that edge transfers the
// command. busy then stays high while the sequencer walks the segment table,
// held in one synchronous RAM read one entry per cycle. Exactly one result is
// shown on rsp with rsp_valid high for a single cycle; the receiver cannot
// stall it and must take it then. busy is already low in the result cycle, so
// the next command can be transferred at the edge that takes the result.
// Operation: a search reads one entry per cycle, then an insertion or removal
// moves each later entry with one read and one write. The RAM port is the
// limiting resource.
// Reset clears the segment count and the configuration registers (base_tile
// 16, tile_limit 2048); the table RAM itself is not cleared and needs no
// clearing pass, since only entries below the count are ever read.
// Configuration is written through cfg_we, cfg_index and cfg_data at any edge
// while the block is idle; the user must ensure this, the block does not enforce it.
`include "tile_ram_first_fit_allocator_core_macros.svh"
module tile_ram_first_fit_allocator_core
  import trfa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  in_item_t   cmd,
  output logic       rsp_valid,
  output out_item_t  rsp,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [11:0] cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_SHIFT_RD = 3'd3;
  localparam logic [2:0] S_SHIFT_WR = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state;
  logic [10:0] base_tile;
  logic [11:0] tile_limit;
  logic [CNT_W-1:0] seg_count;
  in_item_t req;

  logic [CNT_W-1:0] idx;
  logic rd_pending;
  logic have_prev;
  logic [12:0] prev_end;
  logic [CNT_W-1:0] pos;
  logic [12:0] new_start;
  logic found;
  logic [10:0] found_start;
  logic insert_mode;
  logic [CNT_W-1:0] shift_idx;
  segment_t carry;
  out_item_t result;

  logic ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  segment_t ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  segment_t ram_rdata;

  trfa_ram #(.DEPTH(MAX_SEGMENTS)) u_ram (
    .clk(clk), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(ram_wdata),
    .rd_addr(ram_raddr), .rd_data(ram_rdata)
  );

  logic [12:0] rd_end;
  logic [12:0] gap;
  logic [12:0] limit_eff;
  logic tag_hit;

  assign rd_end = {2'b00, ram_rdata.start} + {1'b0, ram_rdata.length};
  assign gap = ({2'b00, ram_rdata.start} >= prev_end)
    ? ({2'b00, ram_rdata.start} - prev_end) : 13'd0;
  assign limit_eff = (tile_limit > 12'(TILE_SPACE)) ? 13'(TILE_SPACE) : {1'b0, tile_limit};
  assign tag_hit = (req.tag != 16'd0) && (ram_rdata.tag == req.tag);

  assign busy = (state != S_IDLE);

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = shift_idx[ADDR_W-1:0];
    ram_wdata = carry;
    ram_raddr = idx[ADDR_W-1:0];
    if (state == S_SHIFT_RD) begin
      ram_raddr = insert_mode ? shift_idx[ADDR_W-1:0] : ADDR_W'(shift_idx + 1'b1);
    end
    if (state == S_SHIFT_WR) begin
      ram_we = 1'b1;
      ram_wdata = insert_mode ? carry : ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      base_tile <= 11'd16;
      tile_limit <= 12'd2048;
      seg_count <= '0;
      rsp_valid <= 1'b0;
      rd_pending <= 1'b0;
    end else begin
      rsp_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BASE_TILE: base_tile <= cfg_data[10:0];
          CFG_TILE_LIMIT: tile_limit <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req <= cmd;
            idx <= '0;
            rd_pending <= 1'b0;
            have_prev <= 1'b0;
            found <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // A read issued last cycle returns now; idx points at the next entry.
          if (rd_pending) begin
            if (req.operation == OP_LOAD) begin
              if (have_prev && ({1'b0, req.tile_count} <= gap) && !found) begin
                found <= 1'b1;
                new_start <= prev_end;
                pos <= CNT_W'(idx - 1'b1);
              end
              prev_end <= rd_end;
              have_prev <= 1'b1;
            end else if (!found) begin
              if ((req.operation == OP_UNLOAD_INDEX && ram_rdata.start == req.tile_start)
                  || (req.operation != OP_UNLOAD_INDEX && tag_hit)) begin
                found <= 1'b1;
                found_start <= ram_rdata.start;
                pos <= CNT_W'(idx - 1'b1);
              end
            end
          end
          if (idx < seg_count && !(found && req.operation != OP_LOAD)
              && !(rd_pending && req.operation != OP_LOAD && !found &&
                   ((req.operation == OP_UNLOAD_INDEX && ram_rdata.start == req.tile_start)
                    || (req.operation != OP_UNLOAD_INDEX && tag_hit)))
              && !(req.operation == OP_LOAD && (seg_count >= CNT_W'(MAX_SEGMENTS)
                   || seg_count == '0))) begin
            idx <= idx + 1'b1;
            rd_pending <= 1'b1;
          end else begin
            rd_pending <= 1'b0;
            if (!rd_pending || req.operation != OP_LOAD) begin
              state <= S_DECIDE;
            end
          end
          if (req.operation == OP_LOAD && rd_pending && found) begin
            rd_pending <= 1'b0;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state <= S_DONE;
          result <= '{INDEX_NONE, ST_NOT_FOUND};
          if (req.operation == OP_LOAD) begin
            logic [12:0] st;
            logic [CNT_W-1:0] p;
            st = found ? new_start : (seg_count == '0) ? {2'b00, base_tile} : prev_end;
            p = found ? pos : seg_count;
            if (seg_count >= CNT_W'(MAX_SEGMENTS)) begin
              result <= '{INDEX_NONE, ST_FULL};
            end else if (st > 13'(TILE_SPACE - 1)
                         || st + {1'b0, req.tile_count} > limit_eff) begin
              result <= '{INDEX_NONE, ST_NO_SPACE};
            end else begin
              result <= '{{5'd0, st[10:0]}, ST_OK};
              carry <= '{st[10:0], req.tile_count, req.tag};
              pos <= p;
              shift_idx <= p;
              insert_mode <= 1'b1;
              seg_count <= seg_count + 1'b1;
              state <= S_SHIFT_RD;
            end
          end else if (found) begin
            result <= '{{5'd0, found_start}, ST_OK};
            if (req.operation != OP_FIND_TAG) begin
              insert_mode <= 1'b0;
              shift_idx <= pos;
              seg_count <= seg_count - 1'b1;
              state <= S_SHIFT_RD;
            end
          end
        end
        S_SHIFT_RD: begin
          // Insert: end of run once the slot beyond the old last entry is written.
          if (insert_mode ? (shift_idx >= seg_count) : (shift_idx >= seg_count)) begin
            if (insert_mode) begin
              state <= S_SHIFT_WR;
            end else begin
              state <= S_DONE;
            end
          end else begin
            state <= S_SHIFT_WR;
          end
        end
        S_SHIFT_WR: begin
          if (insert_mode) begin
            carry <= ram_rdata;
            if (shift_idx + 1'b1 >= seg_count) begin
              state <= S_DONE;
            end else begin
              shift_idx <= shift_idx + 1'b1;
              state <= S_SHIFT_RD;
            end
          end else begin
            shift_idx <= shift_idx + 1'b1;
            state <= S_SHIFT_RD;
          end
        end
        S_DONE: begin
          rsp_valid <= 1'b1;
          rsp <= result;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TRFA_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, seg_count <= CNT_W'(MAX_SEGMENTS))
  `TRFA_ASSERT_NEXT(a_rsp_once, clk, rst, rsp_valid, !rsp_valid)
  `TRFA_ASSERT_IMP(a_rsp_ok_index, clk, rst, rsp_valid && rsp.status == ST_OK,
    rsp.result_index < 16'(TILE_SPACE))
  `TRFA_ASSERT_IMP(a_rsp_fail_index, clk, rst, rsp_valid && rsp.status != ST_OK,
    rsp.result_index == INDEX_NONE)
  `TRFA_ASSERT_IMP(a_write_in_range, clk, rst, ram_we,
    shift_idx < CNT_W'(MAX_SEGMENTS))

endmodule

/* hdl/trfa_ram.sv */
// Single-port-write, single-port-read synchronous RAM holding the segment table.
// Depends on trfa_pkg for the entry type.
module trfa_ram
  import trfa_pkg::*;
#(
  parameter int DEPTH = MAX_SEGMENTS,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic           clk,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  segment_t       wr_data,
  input  logic [AW-1:0]  rd_addr,
  output segment_t       rd_data
);

  segment_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* sim/tile_ram_first_fit_allocator_core_tb.sv */
// Self-checking testbench for the tile RAM first-fit allocator core.
// It predicts every response with its own segment table and checks each transfer.
// Depends on trfa_pkg and tile_ram_first_fit_allocator_core.
module tile_ram_first_fit_allocator_core_tb;
  import trfa_pkg::*;

  localparam int IN_W = $bits(in_item_t);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_item_t cmd = '0;
  logic rsp_valid;
  out_item_t rsp;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_BASE_TILE;
  logic [11:0] cfg_data = '0;

  tile_ram_first_fit_allocator_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow table and configuration of the allocator.
  logic [10:0] seg_start [MAX_SEGMENTS];
  logic [11:0] seg_len [MAX_SEGMENTS];
  logic [15:0] seg_tag [MAX_SEGMENTS];
  int seg_total = 0;
  int base_tile_q = 16;
  int tile_limit_q = 2048;

  out_item_t pending_rsp [$];
  int fail_count = 0;
  int sent = 0;
  int checked = 0;
  int idle_cycles = 0;

  function automatic void drop_segment(int pos);
    for (int k = pos; k + 1 < seg_total; k++) begin
      seg_start[k] = seg_start[k + 1];
      seg_len[k] = seg_len[k + 1];
      seg_tag[k] = seg_tag[k + 1];
    end
    seg_total--;
  endfunction

  function automatic int tag_position(logic [15:0] t);
    if (t == 16'd0) return -1;
    for (int i = 0; i < seg_total; i++)
      if (seg_tag[i] == t) return i;
    return -1;
  endfunction

  function automatic out_item_t allocate(int count, logic [15:0] t);
    out_item_t r;
    int at;
    int pos;
    int lim;
    int fin;
    int gap;
    bit placed;
    r.result_index = INDEX_NONE;
    r.status = ST_NO_SPACE;
    placed = 1'b0;
    if (seg_total >= MAX_SEGMENTS) begin
      r.status = ST_FULL;
      return r;
    end
    if (seg_total == 0) begin
      at = base_tile_q;
      pos = 0;
    end else if (seg_total == 1) begin
      at = seg_start[0] + seg_len[0];
      pos = 1;
    end else begin
      at = 0;
      pos = seg_total;
      for (int i = 0; i + 1 < seg_total && !placed; i++) begin
        fin = seg_start[i] + seg_len[i];
        gap = (seg_start[i + 1] >= fin) ? seg_start[i + 1] - fin : 0;
        if (count <= gap) begin
          at = fin;
          pos = i + 1;
          placed = 1'b1;
        end
      end
      if (!placed) begin
        at = seg_start[seg_total - 1] + seg_len[seg_total - 1];
        pos = seg_total;
      end
    end
    lim = (tile_limit_q > TILE_SPACE) ? TILE_SPACE : tile_limit_q;
    if (at > TILE_SPACE - 1 || at + count > lim) return r;
    for (int k = seg_total; k > pos; k--) begin
      seg_start[k] = seg_start[k - 1];
      seg_len[k] = seg_len[k - 1];
      seg_tag[k] = seg_tag[k - 1];
    end
    seg_start[pos] = 11'(at);
    seg_len[pos] = 12'(count);
    seg_tag[pos] = t;
    seg_total++;
    r.result_index = 16'(at);
    r.status = ST_OK;
    return r;
  endfunction

  function automatic out_item_t predict_response(in_item_t it);
    out_item_t r;
    int pos;
    r.result_index = INDEX_NONE;
    r.status = ST_NOT_FOUND;
    case (it.operation)
      OP_LOAD: begin
        r = allocate(it.tile_count, it.tag);
      end
      OP_UNLOAD_INDEX: begin
        pos = -1;
        for (int i = 0; i < seg_total && pos < 0; i++)
          if (seg_start[i] == it.tile_start) pos = i;
        if (pos >= 0) begin
          r.result_index = 16'(seg_start[pos]);
          r.status = ST_OK;
          drop_segment(pos);
        end
      end
      OP_UNLOAD_TAG: begin
        pos = tag_position(it.tag);
        if (pos >= 0) begin
          r.result_index = 16'(seg_start[pos]);
          r.status = ST_OK;
          drop_segment(pos);
        end
      end
      default: begin
        pos = tag_position(it.tag);
        if (pos >= 0) begin
          r.result_index = 16'(seg_start[pos]);
          r.status = ST_OK;
        end
      end
    endcase
    return r;
  endfunction

  function automatic in_item_t make_cmd(logic [1:0] op, int count, int at, int t);
    in_item_t it;
    it.operation = op;
    it.tile_count = 12'(count);
    it.tile_start = 11'(at);
    it.tag = 16'(t);
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) gap = 0;
    else if (pick < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 60);
    repeat (gap + 1) @(negedge clk);
    start <= 1'b1;
    cmd <= it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_rsp.push_back(predict_response(it));
    sent++;
    @(negedge clk);
    start <= 1'b0;
    cmd <= in_item_t'(IN_W'({$urandom, $urandom}));
  endtask

  task automatic write_config(logic idx, int value);
    wait (pending_rsp.size() == 0);
    repeat (6) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 12'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BASE_TILE) base_tile_q = value & 12'h7FF;
    else tile_limit_q = value & 12'hFFF;
  endtask

  task automatic clear_table();
    while (seg_total > 0)
      send_item(make_cmd(OP_UNLOAD_INDEX, $urandom_range(0, 4095), seg_start[0],
                         $urandom_range(0, 65535)));
  endtask

  task automatic test_basic_operations();
    send_item(make_cmd(OP_FIND_TAG, 0, 0, 5));
    send_item(make_cmd(OP_UNLOAD_TAG, 0, 0, 5));
    send_item(make_cmd(OP_LOAD, 0, 0, 0));
    send_item(make_cmd(OP_LOAD, 1, 2047, 16'hFFFF));
    send_item(make_cmd(OP_LOAD, 2048, 0, 3));
    send_item(make_cmd(OP_LOAD, 4095, 0, 3));
    send_item(make_cmd(OP_LOAD, 10, 0, 7));
    send_item(make_cmd(OP_UNLOAD_INDEX, 0, 16, 0));
    send_item(make_cmd(OP_FIND_TAG, 0, 0, 0));
    send_item(make_cmd(OP_UNLOAD_TAG, 0, 0, 0));
    send_item(make_cmd(OP_FIND_TAG, 0, 0, 16'hFFFF));
    send_item(make_cmd(OP_UNLOAD_TAG, 0, 0, 7));
    send_item(make_cmd(OP_UNLOAD_TAG, 0, 0, 7));
    send_item(make_cmd(OP_UNLOAD_INDEX, 0, 2047, 0));
    send_item(make_cmd(OP_LOAD, 5, 0, 1));
    send_item(make_cmd(OP_LOAD, 5, 0, 2));
    send_item(make_cmd(OP_LOAD, 5, 0, 3));
    send_item(make_cmd(OP_UNLOAD_TAG, 0, 0, 2));
    send_item(make_cmd(OP_LOAD, 6, 0, 4));
    send_item(make_cmd(OP_LOAD, 5, 0, 5));
    send_item(make_cmd(OP_FIND_TAG, 0, 0, 5));
    clear_table();
  endtask

  task automatic test_register_extremes();
    write_config(CFG_BASE_TILE, 2047);
    send_item(make_cmd(OP_LOAD, 1, 0, 9));
    send_item(make_cmd(OP_LOAD, 0, 0, 9));
    clear_table();
    write_config(CFG_BASE_TILE, 0);
    write_config(CFG_TILE_LIMIT, 1);
    send_item(make_cmd(OP_LOAD, 1, 0, 9));
    send_item(make_cmd(OP_LOAD, 1, 0, 9));
    send_item(make_cmd(OP_LOAD, 0, 0, 9));
    clear_table();
    write_config(CFG_TILE_LIMIT, 0);
    send_item(make_cmd(OP_LOAD, 0, 0, 9));
    send_item(make_cmd(OP_LOAD, 1, 0, 9));
    clear_table();
    write_config(CFG_TILE_LIMIT, 4095);
    write_config(CFG_BASE_TILE, 2000);
    send_item(make_cmd(OP_LOAD, 48, 0, 9));
    send_item(make_cmd(OP_LOAD, 1, 0, 9));
    clear_table();
  endtask

  task automatic test_full_table();
    write_config(CFG_BASE_TILE, 16);
    write_config(CFG_TILE_LIMIT, 2048);
    while (seg_total < MAX_SEGMENTS)
      send_item(make_cmd(OP_LOAD, $urandom_range(0, 3), $urandom_range(0, 2047),
                         $urandom_range(1, 65535)));
    send_item(make_cmd(OP_LOAD, 0, 0, 1));
    send_item(make_cmd(OP_LOAD, 1, 0, 2));
    clear_table();
  endtask

  task automatic test_random_traffic(int base, int limit, int n);
    int pick;
    int count;
    int at;
    int t;
    logic [1:0] op;
    write_config(CFG_BASE_TILE, base);
    write_config(CFG_TILE_LIMIT, limit);
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (seg_total > 48) pick = pick / 2 + 40;
      if (pick < 45) op = OP_LOAD;
      else if (pick < 65) op = OP_UNLOAD_INDEX;
      else if (pick < 82) op = OP_UNLOAD_TAG;
      else op = OP_FIND_TAG;
      pick = $urandom_range(0, 99);
      if (pick < 85) count = $urandom_range(0, 30);
      else if (pick < 95) count = $urandom_range(0, 300);
      else count = $urandom_range(0, 4095);
      at = $urandom_range(0, 2047);
      if (op == OP_UNLOAD_INDEX && seg_total > 0 && $urandom_range(0, 9) < 7)
        at = seg_start[$urandom_range(0, seg_total - 1)];
      t = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 20) : $urandom_range(0, 65535);
      send_item(make_cmd(op, count, at, t));
    end
    clear_table();
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid) begin
      if (pending_rsp.size() == 0) begin
        $error("response with nothing outstanding: index %0d status %0d",
               rsp.result_index, rsp.status);
        fail_count++;
      end else begin
        out_item_t want;
        want = pending_rsp.pop_front();
        checked++;
        if (rsp.result_index !== want.result_index) begin
          $error("result_index expected %0d actual %0d", want.result_index,
                 rsp.result_index);
          fail_count++;
        end
        if (rsp.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, rsp.status);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || rsp_valid || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("timeout waiting for a transfer");
      $display("tile_ram_first_fit_allocator_core_tb failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_basic_operations();
    test_register_extremes();
    test_full_table();
    test_random_traffic(16, 2048, 180);
    test_random_traffic(0, 2048, 180);
    test_random_traffic(1000, 1500, 150);
    test_random_traffic($urandom_range(0, 2047), $urandom_range(1, 2048), 130);
    wait (pending_rsp.size() == 0);
    repeat (150) @(posedge clk);
    $display("Sent %0d commands through loads, unloads and finds under several", sent);
    $display("base and limit settings; %0d responses checked.", checked);
    if (fail_count == 0 && pending_rsp.size() == 0) begin
      $display("tile_ram_first_fit_allocator_core_tb passed");
    end else begin
      $display("tile_ram_first_fit_allocator_core_tb failed");
    end
    $finish;
  end

endmodule

/* tile_ram_first_fit_allocator_core.f */
+incdir+hdl
hdl/trfa_pkg.sv
hdl/trfa_ram.sv
hdl/tile_ram_first_fit_allocator_core.sv
sim/tile_ram_first_fit_allocator_core_tb.sv
